>>> hw/rtl/sna_pkg.sv
`timescale 1ns / 1ps
// sna_pkg: shared types, constants and step functions of the nadir angle pipeline.
// No dependencies.
package sna_pkg;

	localparam int CF_BITS      = 30;
	localparam int SQRT_STEPS   = 32;
	localparam int DIV_STEPS    = CF_BITS;
	localparam int CORDIC_STEPS = 30;
	localparam int LATENCY      = 5 + SQRT_STEPS + 2 + DIV_STEPS + 2 + SQRT_STEPS
		+ CORDIC_STEPS + 3;

	localparam logic [1:0] REG_SAT_DISTANCE = 2'd0;
	localparam logic [1:0] REG_SAT_X        = 2'd1;
	localparam logic [1:0] REG_SAT_Y        = 2'd2;
	localparam logic [1:0] REG_SAT_Z        = 2'd3;

	localparam logic signed [33:0] PI_Q30      = 34'sd3373259426;
	localparam logic signed [33:0] HALF_PI_Q30 = 34'sd1686629713;

	localparam logic signed [33:0] ATAN_Q30 [CORDIC_STEPS] = '{
		34'sh03243F6A8, 34'sh01DAC6705, 34'sh00FADBAFC, 34'sh007F56EA6, 34'sh003FEAB76,
		34'sh001FFD55B, 34'sh000FFFAAA, 34'sh0007FFF55, 34'sh0003FFFEA, 34'sh0001FFFFD,
		34'sd1048576, 34'sd524288, 34'sd262144, 34'sd131072, 34'sd65536,
		34'sd32768, 34'sd16384, 34'sd8192, 34'sd4096, 34'sd2048,
		34'sd1024, 34'sd512, 34'sd256, 34'sd128, 34'sd64,
		34'sd32, 34'sd16, 34'sd8, 34'sd4, 34'sd2
	};

	// flags that ride along the back half of the pipeline
	typedef struct packed {
		logic       neg;
		logic       bad;
		logic       rok;
		logic [1:0] ge;
	} side_t;

	typedef struct packed {
		logic [63:0] val;
		logic [31:0] root;
		logic [34:0] rem;
	} sqrt_st_t;

	typedef struct packed {
		logic [53:0] rem;
		logic [53:0] dvs;
		logic [29:0] quo;
	} div_st_t;

	typedef struct packed {
		logic signed [34:0] x;
		logic signed [34:0] y;
		logic signed [33:0] z;
	} cordic_t;

	// one root bit per step, two radicand bits consumed from the top
	function automatic sqrt_st_t sqrt_step(sqrt_st_t a);
		sqrt_st_t o;
		logic [34:0] r;
		logic [34:0] t;
		r = {a.rem[32:0], a.val[63:62]};
		t = {1'b0, a.root, 2'b01};
		o.val = {a.val[61:0], 2'b00};
		if (r >= t) begin
			o.rem  = r - t;
			o.root = {a.root[30:0], 1'b1};
		end else begin
			o.rem  = r;
			o.root = {a.root[30:0], 1'b0};
		end
		return o;
	endfunction

	// restoring division, one quotient bit per step
	function automatic div_st_t div_step(div_st_t a);
		div_st_t o;
		logic [53:0] r;
		r = {a.rem[52:0], 1'b0};
		o.dvs = a.dvs;
		if (r >= a.dvs) begin
			o.rem = r - a.dvs;
			o.quo = {a.quo[28:0], 1'b1};
		end else begin
			o.rem = r;
			o.quo = {a.quo[28:0], 1'b0};
		end
		return o;
	endfunction

	// vectoring rotation; i is a loop constant at every call
	function automatic cordic_t cordic_step(cordic_t a, int i);
		cordic_t o;
		if (!a.y[34]) begin
			o.x = a.x + (a.y >>> i);
			o.y = a.y - (a.x >>> i);
			o.z = a.z + ATAN_Q30[i];
		end else begin
			o.x = a.x - (a.y >>> i);
			o.y = a.y + (a.x >>> i);
			o.z = a.z - ATAN_Q30[i];
		end
		return o;
	endfunction

endpackage

>>> hw/rtl/satellite_nadir_angle_top.sv
`timescale 1ns / 1ps
// satellite_nadir_angle_top: fully pipelined nadir angle of a ground point.
// Depends on sna_pkg.
//
// One ground point per clock: a transfer happens on any rising edge with start
// high (busy is always low), and its result later appears on nadir_angle /
// invalid / beyond_horizon, marked by a one-cycle done strobe.
// The receiver cannot stall the block, so results must be taken
// when done is high. The latency is set by the chain of bit-serial units laid
// out as stages: two 32-step square roots, a 30-step divider and a 30-step
// CORDIC, plus a few arithmetic stages around them. The satellite registers
// (sat_distance, sat_x, sat_y, sat_z) are written through the cfg channel,
// which is always ready; write them only while no point is in flight.
// Outputs: gamma = acos((H^2 + d^2 - R^2) / (2 H d)) in radians with
// ANGLE_FRAC_BITS fraction bits; invalid when H or d is zero or the cosine
// falls outside [-1,1] (angle and horizon flag then 0); beyond_horizon when
// gamma exceeds asin(R/H) and the point radius R does not exceed H.
module satellite_nadir_angle_top import sna_pkg::*; #(
	parameter int ANGLE_FRAC_BITS = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic signed [24:0] point_x,
	input  logic signed [24:0] point_y,
	input  logic signed [24:0] point_z,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [1:0]         cfg_index,
	input  logic [24:0]        cfg_data,
	output logic               done,
	output logic [17:0]        nadir_angle,
	output logic               invalid,
	output logic               beyond_horizon
);

	localparam int ANG_SHIFT = CF_BITS - ANGLE_FRAC_BITS;
	localparam logic [32:0] RND = 33'(1) << (ANG_SHIFT - 1);

	// ---------------- configuration registers ----------------
	logic [23:0]        sat_distance_q;
	logic signed [24:0] sat_x_q, sat_y_q, sat_z_q;

	assign cfg_ready = 1'b1;
	assign busy      = 1'b0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sat_distance_q <= 24'd10793984;
			sat_x_q        <= 25'sd10793984;
			sat_y_q        <= '0;
			sat_z_q        <= '0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_SAT_DISTANCE: sat_distance_q <= cfg_data[23:0];
				REG_SAT_X:        sat_x_q        <= cfg_data;
				REG_SAT_Y:        sat_y_q        <= cfg_data;
				REG_SAT_Z:        sat_z_q        <= cfg_data;
				default: ;
			endcase
		end
	end

	// valid line: payload stages load every cycle, this marks live items
	logic vld_s [LATENCY];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < LATENCY; k++) vld_s[k] <= 1'b0;
		end else begin
			vld_s[0] <= start && !busy;
			for (int k = 1; k < LATENCY; k++) vld_s[k] <= vld_s[k-1];
		end
	end

	assign done = vld_s[LATENCY-1];

	// ---------------- s1: magnitudes of |P| and |S-P| components ----------------
	logic signed [24:0] pt_c [3];
	logic signed [24:0] st_c [3];
	logic [24:0]        ap_c [3];
	logic [25:0]        ad_c [3];
	logic signed [25:0] df_c [3];

	always_comb begin
		pt_c[0] = point_x;
		pt_c[1] = point_y;
		pt_c[2] = point_z;
		st_c[0] = sat_x_q;
		st_c[1] = sat_y_q;
		st_c[2] = sat_z_q;
		for (int i = 0; i < 3; i++) begin
			ap_c[i] = pt_c[i][24] ? 25'(-pt_c[i]) : 25'(pt_c[i]);
			df_c[i] = 26'(st_c[i]) - 26'(pt_c[i]);
			ad_c[i] = df_c[i][25] ? 26'(-df_c[i]) : 26'(df_c[i]);
		end
	end

	logic [24:0] ap_s1 [3];
	logic [25:0] ad_s1 [3];
	logic [48:0] rs_s2 [3];
	logic [50:0] ds_s2 [3];
	logic [47:0] hh_s2;
	logic [49:0] rsq_s3;
	logic [51:0] dsq_s3;
	logic [47:0] hh_s3;
	logic [51:0] sum_s4;
	logic [49:0] rsq_s4;
	logic [51:0] dsq_s4;
	logic        zero_s4;
	logic [51:0] mag_s5;
	logic        neg_s5;
	logic        zero_s5;
	logic [49:0] rsq_s5;
	logic [51:0] dsq_s5;

	always_ff @(posedge clk) begin
		for (int i = 0; i < 3; i++) begin
			ap_s1[i] <= ap_c[i];
			ad_s1[i] <= ad_c[i];
			rs_s2[i] <= ap_s1[i] * ap_s1[i];
			ds_s2[i] <= ad_s1[i] * ad_s1[i];
		end
		hh_s2   <= sat_distance_q * sat_distance_q;
		// s3: squared radius and squared slant range, exact
		rsq_s3  <= 50'(rs_s2[0]) + 50'(rs_s2[1]) + 50'(rs_s2[2]);
		dsq_s3  <= 52'(ds_s2[0]) + 52'(ds_s2[1]) + 52'(ds_s2[2]);
		hh_s3   <= hh_s2;
		// s4: H^2 + d^2, zero-distance test
		sum_s4  <= 52'(hh_s3) + dsq_s3;
		zero_s4 <= (sat_distance_q == '0) || (dsq_s3 == '0);
		rsq_s4  <= rsq_s3;
		dsq_s4  <= dsq_s3;
		// s5: signed numerator as sign and magnitude
		if (sum_s4 >= 52'(rsq_s4)) begin
			neg_s5 <= 1'b0;
			mag_s5 <= sum_s4 - 52'(rsq_s4);
		end else begin
			neg_s5 <= 1'b1;
			mag_s5 <= 52'(rsq_s4) - sum_s4;
		end
		zero_s5 <= zero_s4;
		rsq_s5  <= rsq_s4;
		dsq_s5  <= dsq_s4;
	end

	// ---------------- square roots of d^2 (lane 0) and R^2 (lane 1) ----------------
	sqrt_st_t    sqa_in [2];
	sqrt_st_t    sqa_s [SQRT_STEPS][2];
	logic [51:0] sqa_mag_s [SQRT_STEPS];
	logic        sqa_neg_s [SQRT_STEPS];
	logic        sqa_zero_s [SQRT_STEPS];

	always_comb begin
		sqa_in[0] = '{val: 64'(dsq_s5), root: '0, rem: '0};
		sqa_in[1] = '{val: 64'(rsq_s5), root: '0, rem: '0};
	end

	always_ff @(posedge clk) begin
		for (int l = 0; l < 2; l++) begin
			sqa_s[0][l] <= sqrt_step(sqa_in[l]);
			for (int k = 1; k < SQRT_STEPS; k++) sqa_s[k][l] <= sqrt_step(sqa_s[k-1][l]);
		end
		sqa_mag_s[0]  <= mag_s5;
		sqa_neg_s[0]  <= neg_s5;
		sqa_zero_s[0] <= zero_s5;
		for (int k = 1; k < SQRT_STEPS; k++) begin
			sqa_mag_s[k]  <= sqa_mag_s[k-1];
			sqa_neg_s[k]  <= sqa_neg_s[k-1];
			sqa_zero_s[k] <= sqa_zero_s[k-1];
		end
	end

	// ---------------- s6: denominator 2 H d; s7: range checks ----------------
	logic [50:0] den_s6;
	logic [51:0] mag_s6;
	logic        neg_s6;
	logic        zero_s6;
	logic [24:0] r_s6;
	div_st_t     dva_s7 [2];
	side_t       side_s7;

	always_ff @(posedge clk) begin
		den_s6  <= {50'(sat_distance_q) * 50'(sqa_s[SQRT_STEPS-1][0].root[25:0]), 1'b0};
		mag_s6  <= sqa_mag_s[SQRT_STEPS-1];
		neg_s6  <= sqa_neg_s[SQRT_STEPS-1];
		zero_s6 <= sqa_zero_s[SQRT_STEPS-1];
		r_s6    <= sqa_s[SQRT_STEPS-1][1].root[24:0];

		dva_s7[0]     <= '{rem: 54'(mag_s6), dvs: 54'(den_s6), quo: '0};
		dva_s7[1]     <= '{rem: 54'(r_s6), dvs: 54'(sat_distance_q), quo: '0};
		side_s7.neg   <= neg_s6;
		side_s7.bad   <= zero_s6 || (mag_s6 > 52'(den_s6));
		side_s7.rok   <= r_s6 <= 25'(sat_distance_q);
		side_s7.ge[0] <= mag_s6 >= 52'(den_s6);
		side_s7.ge[1] <= r_s6 >= 25'(sat_distance_q);
	end

	// ---------------- Q.30 ratios: cosine (lane 0) and R/H (lane 1) ----------------
	div_st_t dv_s [DIV_STEPS][2];
	side_t   dv_side_s [DIV_STEPS];

	always_ff @(posedge clk) begin
		for (int l = 0; l < 2; l++) begin
			dv_s[0][l] <= div_step(dva_s7[l]);
			for (int k = 1; k < DIV_STEPS; k++) dv_s[k][l] <= div_step(dv_s[k-1][l]);
		end
		dv_side_s[0] <= side_s7;
		for (int k = 1; k < DIV_STEPS; k++) dv_side_s[k] <= dv_side_s[k-1];
	end

	// ---------------- s8: ratio squared; s9: 1 - ratio^2 in Q.60 ----------------
	logic [30:0] qsel_c [2];
	logic [30:0] q_s8 [2];
	logic [61:0] qq_s8 [2];
	side_t       side_s8;
	logic [30:0] q_s9 [2];
	logic [60:0] v_s9 [2];
	side_t       side_s9;

	always_comb begin
		for (int l = 0; l < 2; l++) begin
			qsel_c[l] = dv_side_s[DIV_STEPS-1].ge[l] ? (31'(1) << CF_BITS)
				: {1'b0, dv_s[DIV_STEPS-1][l].quo};
		end
	end

	always_ff @(posedge clk) begin
		for (int l = 0; l < 2; l++) begin
			q_s8[l]  <= qsel_c[l];
			qq_s8[l] <= qsel_c[l] * qsel_c[l];
			q_s9[l]  <= q_s8[l];
			v_s9[l]  <= 61'((62'(1) << (2 * CF_BITS)) - qq_s8[l]);
		end
		side_s8 <= dv_side_s[DIV_STEPS-1];
		side_s9 <= side_s8;
	end

	// ---------------- complementary roots: sine of gamma (0), cosine of limit (1) ----------------
	sqrt_st_t    sqb_in [2];
	sqrt_st_t    sqb_s [SQRT_STEPS][2];
	logic [30:0] sqb_q_s [SQRT_STEPS][2];
	side_t       sqb_side_s [SQRT_STEPS];

	always_comb begin
		for (int l = 0; l < 2; l++) sqb_in[l] = '{val: 64'(v_s9[l]), root: '0, rem: '0};
	end

	always_ff @(posedge clk) begin
		for (int l = 0; l < 2; l++) begin
			sqb_s[0][l]   <= sqrt_step(sqb_in[l]);
			sqb_q_s[0][l] <= q_s9[l];
			for (int k = 1; k < SQRT_STEPS; k++) begin
				sqb_s[k][l]   <= sqrt_step(sqb_s[k-1][l]);
				sqb_q_s[k][l] <= sqb_q_s[k-1][l];
			end
		end
		sqb_side_s[0] <= side_s9;
		for (int k = 1; k < SQRT_STEPS; k++) sqb_side_s[k] <= sqb_side_s[k-1];
	end

	// ---------------- CORDIC vectoring: gamma (lane 0), horizon limit (lane 1) ----------------
	cordic_t crd_in [2];
	cordic_t crd_s [CORDIC_STEPS][2];
	side_t   crd_side_s [CORDIC_STEPS];

	always_comb begin
		// gamma: angle of (|cos|, sin); limit: angle of (cos, R/H)
		crd_in[0] = '{x: 35'({4'b0, sqb_q_s[SQRT_STEPS-1][0]}),
			y: 35'({3'b0, sqb_s[SQRT_STEPS-1][0].root}), z: '0};
		crd_in[1] = '{x: 35'({3'b0, sqb_s[SQRT_STEPS-1][1].root}),
			y: 35'({4'b0, sqb_q_s[SQRT_STEPS-1][1]}), z: '0};
	end

	always_ff @(posedge clk) begin
		for (int l = 0; l < 2; l++) begin
			crd_s[0][l] <= cordic_step(crd_in[l], 0);
			for (int k = 1; k < CORDIC_STEPS; k++) crd_s[k][l] <= cordic_step(crd_s[k-1][l], k);
		end
		crd_side_s[0] <= sqb_side_s[SQRT_STEPS-1];
		for (int k = 1; k < CORDIC_STEPS; k++) crd_side_s[k] <= crd_side_s[k-1];
	end

	// ---------------- s10: clamp and reflect; s11: round and horizon compare ----------------
	logic signed [33:0] zc_c [2];
	logic [31:0]        g_s10 [2];
	side_t              side_s10;
	logic [32:0]        gam_c [2];
	logic [32:0]        gam_s11;
	logic               bey_s11;
	logic               bad_s11;

	always_comb begin
		for (int l = 0; l < 2; l++) begin
			if (crd_s[CORDIC_STEPS-1][l].z < 0) zc_c[l] = '0;
			else if (crd_s[CORDIC_STEPS-1][l].z > HALF_PI_Q30) zc_c[l] = HALF_PI_Q30;
			else zc_c[l] = crd_s[CORDIC_STEPS-1][l].z;
		end
		for (int l = 0; l < 2; l++) gam_c[l] = (33'(g_s10[l]) + RND) >> ANG_SHIFT;
	end

	always_ff @(posedge clk) begin
		// negative cosine: gamma = pi - acos(|cos|)
		g_s10[0]  <= crd_side_s[CORDIC_STEPS-1].neg ? 32'(PI_Q30 - zc_c[0]) : 32'(zc_c[0]);
		g_s10[1]  <= 32'(zc_c[1]);
		side_s10  <= crd_side_s[CORDIC_STEPS-1];

		gam_s11   <= gam_c[0];
		bey_s11   <= side_s10.rok && (gam_c[0] > gam_c[1]);
		bad_s11   <= side_s10.bad;

		nadir_angle    <= bad_s11 ? '0 : gam_s11[17:0];
		invalid        <= bad_s11;
		beyond_horizon <= !bad_s11 && bey_s11;
	end

endmodule

>>> hw/rtl/sna_checker.sv
`timescale 1ns / 1ps
// sna_props: port-level checks of the nadir angle block, bound to the top level.
// Depends on sna_pkg and satellite_nadir_angle_top.
module sna_props import sna_pkg::*; (
	input logic        clk,
	input logic        arst_n,
	input logic        start,
	input logic        busy,
	input logic        done,
	input logic [17:0] nadir_angle,
	input logic        invalid,
	input logic        beyond_horizon
);

	logic [$clog2(LATENCY+1)-1:0] cnt_q;

	// cycles since reset, saturating; history older than reset is not compared
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (cnt_q != ($clog2(LATENCY+1))'(LATENCY)) begin
			cnt_q <= cnt_q + 1'b1;
		end
	end

	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		(cnt_q == ($clog2(LATENCY+1))'(LATENCY)) |-> (done == $past(start && !busy, LATENCY)))
		else $error("done does not follow a start transfer at fixed latency");

	a_invalid_clean: assert property (@(posedge clk) disable iff (!arst_n)
		(done && invalid) |-> (nadir_angle == '0 && !beyond_horizon))
		else $error("invalid result carries an angle or horizon flag");

	a_horizon_angle: assert property (@(posedge clk) disable iff (!arst_n)
		(done && beyond_horizon) |-> (nadir_angle != '0))
		else $error("beyond_horizon with zero angle");

endmodule

bind satellite_nadir_angle_top sna_props u_sna_props (.*);
